>>> hdl/shadow_poison_bitmap_assert.svh
`ifndef SHADOW_POISON_BITMAP_ASSERT_SVH
`define SHADOW_POISON_BITMAP_ASSERT_SVH
// Assertion helpers shared by the RTL.
`define SPB_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPB_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> hdl/spb_pkg.sv
package spb_pkg;
	localparam logic [2:0] CMD_CHECK = 3'd0;
	localparam logic [2:0] CMD_POISON = 3'd1;
	localparam logic [2:0] CMD_UNPOISON = 3'd2;
	localparam logic [2:0] CMD_REGISTER = 3'd3;
	localparam logic [2:0] CMD_UNREGISTER = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_COVERED = 3'd1;
	localparam logic [2:0] ST_TOO_SMALL = 3'd2;
	localparam logic [2:0] ST_MISALIGNED = 3'd3;
	localparam logic [2:0] ST_TOO_BIG = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL = 3'd5;
	localparam logic [2:0] ST_OVERLAP = 3'd6;
	localparam logic [2:0] ST_NOT_FOUND = 3'd7;

	localparam int unsigned DESC_BYTES = 12;

	typedef struct packed {
		logic [2:0] cmd;
		logic [31:0] addr;
		logic [16:0] size;
	} spb_req_t;

	typedef struct packed {
		logic poisoned;
		logic [2:0] status;
		logic [16:0] heap_size;
	} spb_rsp_t;
endpackage

>>> hdl/spb_stream_if.sv
interface spb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/spb_ram.sv
module spb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/shadow_poison_bitmap.sv
// Channel  Dir  Payload
// req      in   cmd, addr, size
// rsp      out  poisoned, status, heap_size
// After reset a clearing pass writes every shadow word once (REGIONS * slot words,
// 2048 by default) while req is held off.
// Check reads each shadow word it touches in turn; poison, unpoison and the
// register fill read and rewrite each word, register clears the whole slot span first.
// Unregister and rejected commands skip the word walk. The shared word read-modify-write
// path is the limit. A waiting result sits in the output register while the next
// item is accepted and worked on; only the hand-over of that next result waits.
`include "shadow_poison_bitmap_assert.svh"
module shadow_poison_bitmap #(
	parameter int REGIONS = 4,
	parameter int MAX_REGION_BYTES = 65536,
	parameter int GRANULE_BYTES = 4
) (
	input logic clk,
	input logic arst_n,
	spb_stream_if.sink req,
	spb_stream_if.source rsp
);
	import spb_pkg::*;

	localparam int GSH = $clog2(GRANULE_BYTES);
	localparam int SLOT_WORDS = (MAX_REGION_BYTES / GRANULE_BYTES + 31) / 32;
	localparam int SWB = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
	localparam int DEPTH = REGIONS * SLOT_WORDS;
	localparam int AW = $clog2(DEPTH);
	localparam int RB = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int GB = SWB + 5;
	localparam int MIN_BYTES = 128 * GRANULE_BYTES;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_WR = 3'd3;
	localparam logic [2:0] S_RSP = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;

	logic [2:0] state_q;
	logic [31:0] rbeg_q [REGIONS];
	logic [16:0] rlen_q [REGIONS];
	logic [REGIONS-1:0] rvalid_q;

	logic [2:0] cmd_q;
	logic [31:0] addr_q;
	logic [16:0] size_q;
	logic [RB-1:0] slot_q;
	logic [GB:0] g_q;
	logic [GB:0] gend_q;
	logic setv_q;
	logic fill2_q;
	logic hit_q;
	logic [AW:0] init_q;
	spb_rsp_t res_q;
	spb_rsp_t out_q;
	logic out_v_q;

	logic [AW-1:0] ram_addr;
	logic ram_we;
	logic [31:0] ram_wdata, ram_rdata;

	spb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(ram_wdata),
		.raddr(ram_addr), .rdata(ram_rdata)
	);

	// Lookup from the captured request.
	logic [32:0] a_end;
	logic found;
	logic [RB-1:0] found_s;
	logic [RB-1:0] free_s;
	logic has_free, ovl, unreg_hit;
	logic [RB-1:0] unreg_s;
	logic [32:0] rend [REGIONS];

	always_comb begin
		a_end = {1'b0, addr_q} + {16'd0, size_q};
		found = 1'b0;
		found_s = '0;
		has_free = 1'b0;
		free_s = '0;
		ovl = 1'b0;
		unreg_hit = 1'b0;
		unreg_s = '0;
		for (int k = REGIONS - 1; k >= 0; k--) begin
			rend[k] = {1'b0, rbeg_q[k]} + {16'd0, rlen_q[k]};
			if (rvalid_q[k] && addr_q >= rbeg_q[k] && {1'b0, addr_q} < rend[k]) begin
				found = 1'b1;
				found_s = RB'(k);
			end
			if (!rvalid_q[k]) begin
				has_free = 1'b1;
				free_s = RB'(k);
			end
			if (rvalid_q[k] && {1'b0, addr_q} < rend[k] && {1'b0, rbeg_q[k]} < a_end)
				ovl = 1'b1;
			if (rvalid_q[k] && rbeg_q[k] == addr_q) begin
				unreg_hit = 1'b1;
				unreg_s = RB'(k);
			end
		end
	end

	logic covered, reg_ok, walk;
	assign covered = found && (a_end <= rend[found_s]);
	assign reg_ok = (addr_q != 0) && (size_q >= 17'(MIN_BYTES)) && (addr_q[GSH-1:0] == '0)
		&& (32'(size_q) <= 32'(MAX_REGION_BYTES)) && has_free && !ovl;
	assign walk = ((cmd_q == CMD_CHECK || cmd_q == CMD_POISON || cmd_q == CMD_UNPOISON)
		&& covered) || (cmd_q == CMD_REGISTER && reg_ok);

	logic [31:0] goff;
	logic [GSH+17:0] off_sum;
	logic [16:0] ngran_chk;
	logic [16:0] heap;
	always_comb begin
		goff = addr_q - rbeg_q[found_s];
		off_sum = (GSH+18)'(addr_q[GSH-1:0]) + (GSH+18)'(size_q)
			+ (GSH+18)'(GRANULE_BYTES - 1);
		ngran_chk = 17'(off_sum >> GSH);
		if (ngran_chk == 0)
			ngran_chk = 17'd1;
		heap = size_q - 17'(DESC_BYTES) - 17'({size_q >> (GSH + 5), 2'b00});
	end

	logic [SWB-1:0] word_idx;
	logic [AW-1:0] cur_addr;
	logic [31:0] mask;
	always_comb begin
		word_idx = SWB'(g_q >> 5);
		cur_addr = AW'(slot_q * SLOT_WORDS + word_idx);
		mask = '0;
		for (int b = 0; b < 32; b++)
			if ({g_q[GB:5], 5'(b)} >= g_q && {g_q[GB:5], 5'(b)} < gend_q)
				mask[b] = 1'b1;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = '0;
		ram_addr = cur_addr;
		if (state_q == S_INIT) begin
			ram_we = 1'b1;
			ram_addr = init_q[AW-1:0];
		end else if (state_q == S_WR && cmd_q != CMD_CHECK) begin
			ram_we = 1'b1;
			ram_wdata = setv_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	logic [GB:0] cap;
	logic [GB:0] next_g;
	always_comb begin
		cap = (GB+1)'(SLOT_WORDS * 32);
		next_g = {g_q[GB:5] + 1'b1, 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			rvalid_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			res_q <= '0;
			cmd_q <= '0;
			addr_q <= '0;
			size_q <= '0;
			slot_q <= '0;
			g_q <= '0;
			gend_q <= '0;
			setv_q <= 1'b0;
			fill2_q <= 1'b0;
			hit_q <= 1'b0;
			for (int k = 0; k < REGIONS; k++) begin
				rbeg_q[k] <= '0;
				rlen_q[k] <= '0;
			end
		end else begin
			if (state_q == S_RSP && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
				out_q <= res_q;
			end else if (rsp.ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (AW+1)'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						cmd_q <= req.data.cmd;
						addr_q <= req.data.addr;
						size_q <= req.data.size;
						res_q <= '0;
						hit_q <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= walk ? S_RD : S_RSP;
					if (cmd_q == CMD_CHECK || cmd_q == CMD_POISON || cmd_q == CMD_UNPOISON) begin
						if (!covered) begin
							res_q.status <= ST_NOT_COVERED;
						end else begin
							slot_q <= found_s;
							g_q <= (GB+1)'(goff >> GSH);
							setv_q <= (cmd_q == CMD_POISON);
							fill2_q <= 1'b0;
							if (cmd_q == CMD_CHECK)
								gend_q <= (GB+1)'((32'(goff >> GSH) + 32'(ngran_chk)) > 32'(cap)
									? 32'(cap) : (32'(goff >> GSH) + 32'(ngran_chk)));
							else
								gend_q <= (GB+1)'((32'(goff >> GSH) + 32'(size_q >> GSH)) > 32'(cap)
									? 32'(cap) : (32'(goff >> GSH) + 32'(size_q >> GSH)));
						end
					end else if (cmd_q == CMD_REGISTER) begin
						if (addr_q == 0 || size_q < 17'(MIN_BYTES))
							res_q.status <= ST_TOO_SMALL;
						else if (addr_q[GSH-1:0] != '0)
							res_q.status <= ST_MISALIGNED;
						else if (32'(size_q) > 32'(MAX_REGION_BYTES))
							res_q.status <= ST_TOO_BIG;
						else if (!has_free)
							res_q.status <= ST_TABLE_FULL;
						else if (ovl)
							res_q.status <= ST_OVERLAP;
						else begin
							rbeg_q[free_s] <= addr_q;
							rlen_q[free_s] <= size_q;
							rvalid_q[free_s] <= 1'b1;
							res_q.heap_size <= heap;
							slot_q <= free_s;
							g_q <= '0;
							gend_q <= cap;
							setv_q <= 1'b0;
							fill2_q <= 1'b1;
						end
					end else if (cmd_q == CMD_UNREGISTER) begin
						if (unreg_hit)
							rvalid_q[unreg_s] <= 1'b0;
						else
							res_q.status <= ST_NOT_FOUND;
					end
				end
				S_RD: begin
					if (g_q >= gend_q) begin
						if (fill2_q) begin
							fill2_q <= 1'b0;
							setv_q <= 1'b1;
							g_q <= '0;
							gend_q <= (GB+1)'(size_q >> GSH);
						end else begin
							res_q.poisoned <= (cmd_q == CMD_CHECK) && hit_q;
							state_q <= S_RSP;
						end
					end else
						state_q <= S_WR;
				end
				S_WR: begin
					if (cmd_q == CMD_CHECK && (ram_rdata & mask) != 0)
						hit_q <= 1'b1;
					g_q <= next_g;
					state_q <= S_RD;
				end
				S_RSP: begin
					if (!out_v_q || rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SPB_ASSERT_NEXT(a_no_req_in_init, clk, arst_n, state_q == S_INIT, !req.ready || state_q == S_IDLE, "ready in clear")
	`SPB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "rsp dropped")
endmodule

>>> sim/tb_shadow_poison_bitmap.sv
`timescale 1ns / 100ps

module tb_shadow_poison_bitmap;
	import spb_pkg::*;

	localparam int REGIONS = 4;
	localparam int MAX_REGION_BYTES = 65536;
	localparam int GRANULE_BYTES = 4;
	localparam int SLOT_BITS = ((MAX_REGION_BYTES / GRANULE_BYTES + 31) / 32) * 32;
	localparam int MIN_REGION_BYTES = 128 * GRANULE_BYTES;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT = 40000;

	typedef struct {
		spb_req_t req;
		bit fixed;
		spb_rsp_t rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	spb_stream_if #(.T(spb_req_t)) req_if();
	spb_stream_if #(.T(spb_rsp_t)) rsp_if();

	shadow_poison_bitmap #(
		.REGIONS(REGIONS),
		.MAX_REGION_BYTES(MAX_REGION_BYTES),
		.GRANULE_BYTES(GRANULE_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	longint region_base[REGIONS];
	longint region_len[REGIONS];
	bit region_used[REGIONS];
	bit granule_poison[REGIONS][SLOT_BITS];

	spb_rsp_t pending_rsp[$];
	stim_row_t directed_rows[$];
	bit failed;
	int idle_cycles = 0;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic spb_rsp_t shadow_predict(spb_req_t r);
		spb_rsp_t o;
		longint a;
		longint sz;
		longint g0;
		longint n;
		longint off;
		int s;
		int free_slot;
		o = '0;
		a = r.addr;
		sz = r.size;
		s = -1;
		if (r.cmd == CMD_CHECK || r.cmd == CMD_POISON || r.cmd == CMD_UNPOISON) begin
			for (int k = 0; k < REGIONS; k++) begin
				if (region_used[k] && a >= region_base[k] &&
						a < region_base[k] + region_len[k]) begin
					if (a + sz <= region_base[k] + region_len[k])
						s = k;
					break;
				end
			end
			if (s < 0) begin
				o.status = ST_NOT_COVERED;
			end else begin
				g0 = (a - region_base[s]) / GRANULE_BYTES;
				if (r.cmd == CMD_CHECK) begin
					off = a % GRANULE_BYTES;
					n = 1;
					if (off + sz > GRANULE_BYTES)
						n = (off + sz + GRANULE_BYTES - 1) / GRANULE_BYTES;
					for (longint i = 0; i < n && g0 + i < SLOT_BITS; i++)
						if (granule_poison[s][g0 + i])
							o.poisoned = 1'b1;
				end else begin
					n = sz / GRANULE_BYTES;
					for (longint i = 0; i < n && g0 + i < SLOT_BITS; i++)
						granule_poison[s][g0 + i] = (r.cmd == CMD_POISON);
				end
			end
		end else if (r.cmd == CMD_REGISTER) begin
			if (a == 0 || sz < MIN_REGION_BYTES) begin
				o.status = ST_TOO_SMALL;
			end else if (a % GRANULE_BYTES != 0) begin
				o.status = ST_MISALIGNED;
			end else if (sz > MAX_REGION_BYTES) begin
				o.status = ST_TOO_BIG;
			end else begin
				free_slot = -1;
				for (int k = REGIONS - 1; k >= 0; k--)
					if (!region_used[k])
						free_slot = k;
				if (free_slot < 0) begin
					o.status = ST_TABLE_FULL;
				end else begin
					for (int k = 0; k < REGIONS; k++)
						if (region_used[k] && a < region_base[k] + region_len[k] &&
								region_base[k] < a + sz)
							o.status = ST_OVERLAP;
					if (o.status == ST_OK) begin
						region_base[free_slot] = a;
						region_len[free_slot] = sz;
						region_used[free_slot] = 1'b1;
						for (int i = 0; i < SLOT_BITS; i++)
							granule_poison[free_slot][i] = (i < sz / GRANULE_BYTES);
						o.heap_size = 17'(sz - DESC_BYTES - 4 * (sz / (GRANULE_BYTES * 32)));
					end
				end
			end
		end else if (r.cmd == CMD_UNREGISTER) begin
			o.status = ST_NOT_FOUND;
			for (int k = 0; k < REGIONS; k++) begin
				if (region_used[k] && region_base[k] == a) begin
					region_used[k] = 1'b0;
					o.status = ST_OK;
					break;
				end
			end
		end
		return o;
	endfunction

	function automatic spb_req_t make_req(logic [2:0] c, logic [31:0] a, logic [16:0] sz);
		spb_req_t r;
		r.cmd = c;
		r.addr = a;
		r.size = sz;
		return r;
	endfunction

	function automatic spb_rsp_t make_rsp(logic p, logic [2:0] st, logic [16:0] h);
		spb_rsp_t o;
		o.poisoned = p;
		o.status = st;
		o.heap_size = h;
		return o;
	endfunction

	task automatic add_row(spb_req_t r, bit fixed, spb_rsp_t o);
		stim_row_t row;
		row.req = r;
		row.fixed = fixed;
		row.rsp = o;
		directed_rows.push_back(row);
	endtask

	function automatic spb_req_t random_req();
		int pick;
		int slots[$];
		int s;
		longint span;
		longint a;
		longint sz;
		spb_req_t r;
		for (int k = 0; k < REGIONS; k++)
			if (region_used[k])
				slots.push_back(k);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.cmd = 3'($urandom_range(0, 7));
			r.addr = $urandom();
			r.size = 17'($urandom());
		end else if (pick < 20 && slots.size() < REGIONS) begin
			r.cmd = CMD_REGISTER;
			if ($urandom_range(0, 9) == 0)
				r.addr = 32'hFFFF_0000 + 32'($urandom_range(0, 15) * 4);
			else
				r.addr = 32'($urandom_range(1, 12) * 32'h4000 + $urandom_range(0, 7) * 4);
			if ($urandom_range(0, 9) == 0)
				r.size = 17'(MAX_REGION_BYTES);
			else
				r.size = 17'($urandom_range(MIN_REGION_BYTES, 3000));
		end else if (pick < 30 || slots.size() == 0) begin
			r.cmd = (slots.size() == 0) ? CMD_REGISTER : CMD_UNREGISTER;
			if (slots.size() != 0 && $urandom_range(0, 4) != 0)
				r.addr = 32'(region_base[slots[$urandom_range(0, slots.size() - 1)]]);
			else
				r.addr = 32'($urandom_range(1, 12) * 32'h4000);
			r.size = 17'($urandom_range(MIN_REGION_BYTES, 2000));
		end else begin
			pick = $urandom_range(0, 99);
			r.cmd = (pick < 50) ? CMD_CHECK : (pick < 75) ? CMD_POISON : CMD_UNPOISON;
			s = slots[$urandom_range(0, slots.size() - 1)];
			span = region_len[s];
			a = region_base[s] + $urandom_range(0, 32'(span - 1));
			if ($urandom_range(0, 3) == 0)
				sz = $urandom_range(0, 32'(span));
			else
				sz = $urandom_range(0, 40);
			if ($urandom_range(0, 7) != 0 && a + sz > region_base[s] + span)
				sz = region_base[s] + span - a;
			r.addr = 32'(a);
			r.size = 17'(sz);
		end
		return r;
	endfunction

	task automatic send_item(spb_req_t r, bit fixed, spb_rsp_t fixed_rsp);
		spb_rsp_t predicted;
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_if.data <= r;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = shadow_predict(r);
		pending_rsp.push_back(fixed ? fixed_rsp : predicted);
	endtask

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result %p", rsp_if.data);
				failed = 1'b1;
			end else begin
				if (rsp_if.data.poisoned !== pending_rsp[0].poisoned) begin
					$error("poisoned: expected %0d, got %0d",
						pending_rsp[0].poisoned, rsp_if.data.poisoned);
					failed = 1'b1;
				end
				if (rsp_if.data.status !== pending_rsp[0].status) begin
					$error("status: expected %0d, got %0d",
						pending_rsp[0].status, rsp_if.data.status);
					failed = 1'b1;
				end
				if (rsp_if.data.heap_size !== pending_rsp[0].heap_size) begin
					$error("heap_size: expected %0d, got %0d",
						pending_rsp[0].heap_size, rsp_if.data.heap_size);
					failed = 1'b1;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 300) % 3)
			0: begin
				rsp_if.ready <= 1'b1;
			end
			1: begin
				rsp_if.ready <= ($urandom_range(0, 1) == 1);
			end
			default: begin
				rsp_if.ready <= (stall_phase % 11) > 6;
			end
		endcase
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		failed = 1'b0;
		burst_left = 0;
		for (int k = 0; k < REGIONS; k++) begin
			region_base[k] = 0;
			region_len[k] = 0;
			region_used[k] = 1'b0;
			for (int i = 0; i < SLOT_BITS; i++)
				granule_poison[k][i] = 1'b0;
		end

		add_row(make_req(CMD_CHECK, 32'h1000, 17'd4), 1, make_rsp(0, ST_NOT_COVERED, 0));
		add_row(make_req(CMD_REGISTER, 32'h0, 17'd512), 1, make_rsp(0, ST_TOO_SMALL, 0));
		add_row(make_req(CMD_REGISTER, 32'h1000, 17'd511), 1, make_rsp(0, ST_TOO_SMALL, 0));
		add_row(make_req(CMD_REGISTER, 32'h1002, 17'd512), 1, make_rsp(0, ST_MISALIGNED, 0));
		add_row(make_req(CMD_REGISTER, 32'h1000, 17'd65537), 1, make_rsp(0, ST_TOO_BIG, 0));
		add_row(make_req(CMD_UNREGISTER, 32'h1000, 17'd0), 1, make_rsp(0, ST_NOT_FOUND, 0));
		add_row(make_req(CMD_REGISTER, 32'h10000, 17'd65536), 1, make_rsp(0, ST_OK, 17'd63476));
		add_row(make_req(CMD_REGISTER, 32'hFFFF0000, 17'd65536), 1,
			make_rsp(0, ST_OK, 17'd63476));
		add_row(make_req(CMD_REGISTER, 32'h20000, 17'd512), 1, make_rsp(0, ST_OK, 17'd484));
		add_row(make_req(CMD_REGISTER, 32'h30000, 17'd1000), 1, make_rsp(0, ST_OK, 17'd960));
		add_row(make_req(CMD_REGISTER, 32'h40000, 17'd512), 1, make_rsp(0, ST_TABLE_FULL, 0));
		add_row(make_req(CMD_UNREGISTER, 32'h30000, 17'h1FFFF), 1, make_rsp(0, ST_OK, 0));
		add_row(make_req(CMD_REGISTER, 32'h1F000, 17'd8192), 1, make_rsp(0, ST_OVERLAP, 0));
		add_row(make_req(CMD_CHECK, 32'h10000, 17'd0), 1, make_rsp(1, ST_OK, 0));
		add_row(make_req(CMD_UNPOISON, 32'h10001, 17'd7), 0, '0);
		add_row(make_req(CMD_CHECK, 32'h10003, 17'd2), 0, '0);
		add_row(make_req(CMD_CHECK, 32'h1FFFC, 17'd5), 1, make_rsp(0, ST_NOT_COVERED, 0));
		add_row(make_req(CMD_POISON, 32'hFFFFFFFC, 17'd4), 0, '0);
		add_row(make_req(CMD_CHECK, 32'hFFFFFFFF, 17'd1), 0, '0);
		add_row(make_req(CMD_UNPOISON, 32'hFFFF0000, 17'd65536), 0, '0);
		add_row(make_req(CMD_CHECK, 32'hFFFF0000, 17'd65536), 0, '0);
		add_row(make_req(3'd5, 32'hFFFFFFFF, 17'h1FFFF), 1, make_rsp(0, ST_OK, 0));
		add_row(make_req(3'd7, 32'h0, 17'd0), 1, make_rsp(0, ST_OK, 0));
		add_row(make_req(CMD_REGISTER, 32'h30000, 17'd1001), 0, '0);
		add_row(make_req(CMD_CHECK, 32'h303E8, 17'd1), 0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_item(random_req(), 0, '0);
		req_if.valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
